// File: sv/float32_divide_truncating_defines.svh
// ----------------------------------------------------------------------------
// float32_divide_truncating_defines
// Assertion macros used by the divider's checked file.
// ----------------------------------------------------------------------------
`ifndef FLOAT32_DIVIDE_TRUNCATING_DEFINES_SVH
`define FLOAT32_DIVIDE_TRUNCATING_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define FDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define FDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/fdt_pkg.sv
// ----------------------------------------------------------------------------
// fdt_pkg
// Shared constants and types for the truncating single-precision divider.
// ----------------------------------------------------------------------------
package fdt_pkg;
    localparam int FRAC_BITS = 23;
    localparam int MANT_W    = 24;
    localparam int EXP_W     = 8;
    localparam int EXPS_W    = 10;
    localparam int QUO_W     = 24;
    localparam int STAT_W    = 2;
    localparam int STAGE_BITS_DEF = 2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_DIV0  = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVF   = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNF   = 2'd3;

    // Per-word side information carried down the divider pipe.
    typedef struct packed {
        logic                     sign;
        logic signed [EXPS_W-1:0] exp;
        logic                     div0;
        logic                     zero;
    } t_side;
endpackage

// File: sv/float32_divide_truncating.sv
// ----------------------------------------------------------------------------
// float32_divide_truncating
// Single-precision divide, truncated quotient, saturating exponent.
// ----------------------------------------------------------------------------
// Use: drive i_dividend_bits and i_divisor_bits with start high; a word is
// taken at any edge where start is high (busy is tied low: the pipe never
// blocks). Each word gives one result on o_quotient_bits / o_status with
// o_done high for exactly one cycle; the receiver cannot stall.
// Pipeline: 1 input register + ceil(23/STAGE_BITS) divider stages + 1 output
// register. Throughput is one word per cycle, set by the radix-2 stage chain
// (STAGE_BITS bits per stage).
// Quotient math: the dividend mantissa (hidden one forced) is divided by the
// divisor mantissa; the first quotient bit is the ma >= mb test at entry,
// and since the dividend mantissa is below twice the divisor, 23 more bits
// complete the 24-bit quotient.
// A zero top bit means one normalize shift and an exponent decrement.
// Reset (synchronous, active low) clears all valid bits; in-flight words
// are dropped. Status: 0 ok, 1 divide by zero, 2 overflow, 3 underflow.
// ----------------------------------------------------------------------------
`include "float32_divide_truncating_defines.svh"

module float32_divide_truncating #(
    parameter int STAGE_BITS = fdt_pkg::STAGE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [31:0]                i_dividend_bits,
    input  logic [31:0]                i_divisor_bits,
    output logic                       o_done,
    output logic [31:0]                o_quotient_bits,
    output logic [fdt_pkg::STAT_W-1:0] o_status
);
    import fdt_pkg::*;

    // 24 quotient bits; first comes from the ma >= mb test done at entry.
    localparam int NSTG = (QUO_W - 1 + STAGE_BITS - 1) / STAGE_BITS;
    localparam int BITS_DONE = 1 + NSTG * STAGE_BITS;
    localparam int EXTRA = BITS_DONE - QUO_W;

    logic              w_vld [NSTG+1];
    t_side             w_side[NSTG+1];
    logic [MANT_W:0]   w_rem [NSTG+1];
    logic [MANT_W-1:0] w_dvs [NSTG+1];
    logic [BITS_DONE-1:0] w_quo [NSTG+1];

    logic              r_vld;
    t_side             r_side;
    logic [MANT_W:0]   r_rem;
    logic [MANT_W-1:0] r_dvs;
    logic [BITS_DONE-1:0] r_quo;

    logic [MANT_W-1:0] n_ma, n_mb;
    t_side             n_side;

    assign busy = 1'b0;

    always_comb begin
        n_ma        = {1'b1, i_dividend_bits[FRAC_BITS-1:0]};
        n_mb        = {1'b1, i_divisor_bits[FRAC_BITS-1:0]};
        n_side.sign = i_dividend_bits[31] ^ i_divisor_bits[31];
        n_side.exp  = EXPS_W'(signed'({2'b00, i_dividend_bits[30:23]}))
                    - EXPS_W'(signed'({2'b00, i_divisor_bits[30:23]}))
                    + EXPS_W'(127);
        n_side.div0 = (i_divisor_bits[30:0] == '0);
        n_side.zero = (i_dividend_bits[30:0] == '0);
    end

    // Entry stage: first quotient bit and starting remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start;
        end
        r_side <= n_side;
        r_dvs  <= n_mb;
        if (n_ma >= n_mb) begin
            r_rem <= {1'b0, n_ma - n_mb};
            r_quo <= BITS_DONE'(1);
        end else begin
            r_rem <= {1'b0, n_ma};
            r_quo <= '0;
        end
    end

    assign w_vld[0]  = r_vld;
    assign w_side[0] = r_side;
    assign w_rem[0]  = r_rem;
    assign w_dvs[0]  = r_dvs;
    assign w_quo[0]  = r_quo;

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        fdt_div_stage #(.STAGE_BITS(STAGE_BITS), .QACC_W(BITS_DONE)) u_stg (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (w_vld[g]),
            .i_side (w_side[g]),
            .i_rem  (w_rem[g]),
            .i_dvs  (w_dvs[g]),
            .i_quo  (w_quo[g]),
            .o_vld  (w_vld[g+1]),
            .o_side (w_side[g+1]),
            .o_rem  (w_rem[g+1]),
            .o_dvs  (w_dvs[g+1]),
            .o_quo  (w_quo[g+1])
        );
    end

    // Extra bits developed past 24 (odd split) are dropped: truncation of
    // a longer quotient leaves the 24-bit truncated one.
    logic [QUO_W-1:0]         w_q;
    logic [FRAC_BITS-1:0]     w_frac;
    logic signed [EXPS_W-1:0] w_exp;
    t_side                    w_s;
    logic [31:0]              n_bits;
    logic [STAT_W-1:0]        n_stat;

    always_comb begin
        w_s = w_side[NSTG];
        w_q = w_quo[NSTG][EXTRA +: QUO_W];
        if (w_q[QUO_W-1]) begin
            w_frac = w_q[FRAC_BITS-1:0];
            w_exp  = w_s.exp;
        end else begin
            w_frac = {w_q[FRAC_BITS-2:0], 1'b0};
            w_exp  = w_s.exp - EXPS_W'(1);
        end
        if (w_s.div0) begin
            n_bits = '0;
            n_stat = ST_DIV0;
        end else if (w_s.zero) begin
            n_bits = '0;
            n_stat = ST_OK;
        end else if (w_exp >= EXPS_W'(255)) begin
            n_bits = {w_s.sign, 8'hFF, 23'd0};
            n_stat = ST_OVF;
        end else if (w_exp <= EXPS_W'(0)) begin
            n_bits = {w_s.sign, 31'd0};
            n_stat = ST_UNF;
        end else begin
            n_bits = {w_s.sign, w_exp[EXP_W-1:0], w_frac};
            n_stat = ST_OK;
        end
    end

    logic              r_done;
    logic [31:0]       r_bits;
    logic [STAT_W-1:0] r_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_vld[NSTG];
        end
        r_bits <= n_bits;
        r_stat <= n_stat;
    end

    assign o_done          = r_done;
    assign o_quotient_bits = r_bits;
    assign o_status        = r_stat;

    `FDT_ASSERT_IMP(a_div0_zero, i_clk, i_rst_n, o_done && o_status == ST_DIV0, o_quotient_bits == 32'd0, "div by zero must give +0")
    `FDT_ASSERT_IMP(a_ovf_inf, i_clk, i_rst_n, o_done && o_status == ST_OVF, o_quotient_bits[30:0] == 31'h7F800000, "overflow must give infinity")
    `FDT_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, w_vld[NSTG], o_done, "result strobe lost")
endmodule

// File: sv/fdt_div_stage.sv
// ----------------------------------------------------------------------------
// fdt_div_stage
// Restoring-division stage: STAGE_BITS quotient bits per register stage.
// ----------------------------------------------------------------------------
module fdt_div_stage #(
    parameter int STAGE_BITS = fdt_pkg::STAGE_BITS_DEF,
    parameter int QACC_W     = fdt_pkg::QUO_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  fdt_pkg::t_side            i_side,
    input  logic [fdt_pkg::MANT_W:0]  i_rem,
    input  logic [fdt_pkg::MANT_W-1:0] i_dvs,
    input  logic [QACC_W-1:0]         i_quo,
    output logic                      o_vld,
    output fdt_pkg::t_side            o_side,
    output logic [fdt_pkg::MANT_W:0]  o_rem,
    output logic [fdt_pkg::MANT_W-1:0] o_dvs,
    output logic [QACC_W-1:0]         o_quo
);
    import fdt_pkg::*;

    logic [MANT_W:0]   n_rem;
    logic [QACC_W-1:0] n_quo;
    logic [MANT_W+1:0] w_sh;
    logic              r_vld;
    t_side             r_side;
    logic [MANT_W:0]   r_rem;
    logic [MANT_W-1:0] r_dvs;
    logic [QACC_W-1:0] r_quo;

    // Remainder stays below the divisor; shift in zero, compare, subtract.
    always_comb begin
        n_rem = i_rem;
        n_quo = i_quo;
        w_sh  = '0;
        for (int k = 0; k < STAGE_BITS; k++) begin
            w_sh  = {n_rem, 1'b0};
            n_quo = {n_quo[QACC_W-2:0], 1'b0};
            if (w_sh >= {2'b00, i_dvs}) begin
                w_sh     = w_sh - {2'b00, i_dvs};
                n_quo[0] = 1'b1;
            end
            n_rem = w_sh[MANT_W:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_side <= i_side;
        r_rem  <= n_rem;
        r_dvs  <= i_dvs;
        r_quo  <= n_quo;
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_dvs  = r_dvs;
    assign o_quo  = r_quo;
endmodule
